// ----- design/qdec_pkg.sv -----
// Package for the quadrature decoder with speed scaling.
// Holds field widths, configuration register codes and reset values, and the Gray step table.
// No dependencies; every other design file imports it.
package qdec_pkg;

  localparam int LIMIT_W = 16;
  localparam int MULT_W  = 4;
  localparam int DIR_W   = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_LIMIT  = 2'd0,
    REG_FAST_LIMIT      = 2'd1,
    REG_SLOW_LIMIT      = 2'd2,
    REG_FAST_MULTIPLIER = 2'd3
  } cfg_idx_t;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST  = 16'd2;
  localparam logic [LIMIT_W-1:0] FAST_LIMIT_RST      = 16'd75;
  localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST      = 16'd1000;
  localparam logic [MULT_W-1:0]  FAST_MULTIPLIER_RST = 4'd10;

  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic [LIMIT_W-1:0] fast_limit;
    logic [LIMIT_W-1:0] slow_limit;
    logic [MULT_W-1:0]  fast_multiplier;
  } cfg_t;

  typedef enum logic [1:0] {
    SENSE_NONE = 2'd0,
    SENSE_UP   = 2'd1,
    SENSE_DOWN = 2'd2
  } sense_t;

  // Increasing order is 00 -> 10 -> 11 -> 01 -> 00 (A is the high bit).
  function automatic sense_t step_sense(input logic [1:0] from, input logic [1:0] to);
    logic [1:0] up;
    logic [1:0] dn;
    case (from)
      2'b00: begin up = 2'b10; dn = 2'b01; end
      2'b10: begin up = 2'b11; dn = 2'b00; end
      2'b11: begin up = 2'b01; dn = 2'b10; end
      default: begin up = 2'b00; dn = 2'b11; end
    endcase
    if (to == up) begin
      step_sense = SENSE_UP;
    end else if (to == dn) begin
      step_sense = SENSE_DOWN;
    end else begin
      step_sense = SENSE_NONE;
    end
  endfunction

endpackage

// ----- design/qdec_if.sv -----
// Channel interfaces of the quadrature decoder: encoder samples in, speed reports out.
// Depends on qdec_pkg for the report width.
interface qdec_in_if;
  logic valid;
  logic ready;
  logic chan_a;
  logic chan_b;

  modport source (output valid, output chan_a, output chan_b, input ready);
  modport sink   (input valid, input chan_a, input chan_b, output ready);
endinterface

interface qdec_out_if import qdec_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] speed_direction;

  modport source (output valid, output speed_direction, input ready);
  modport sink   (input valid, input speed_direction, output ready);
endinterface

// ----- design/quadrature_decoder_with_speed.sv -----
// Top level of the quadrature decoder with speed scaling.
// Depends on qdec_pkg, qdec_if, qdec_cfg and qdec_core.
//
// Usage: each item on in_chan is one sample of encoder channels A and B taken
// once per tick. For every sample one item leaves on out_chan carrying the
// signed speed report: 0 for none, +/-1 for a slow step, +/-fast_multiplier
// for a fast step. Limits and the multiplier are written on the cfg_ port
// (index 0 debounce, 1 fast, 2 slow, 3 multiplier) while the block is idle.
//
// After acceptance the sample first sits in the input register, then its
// result is in the result register, where the receiver can take it.
// Throughput is one item per cycle while the receiver does not stall; the
// state update is a single pass of compare and increment logic between
// those two registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more sample; in_chan.ready then drops until
// out_chan.ready returns. Reset clears both valid flags and the decoder
// state and loads the default limits; the first sample only seeds the phase.
module quadrature_decoder_with_speed import qdec_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  qdec_in_if.sink              in_chan,
  qdec_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  cfg_t             cfg;
  logic             in_valid_r;
  logic             chan_a_r;
  logic             chan_b_r;
  logic             out_valid_r;
  logic [DIR_W-1:0] dir_out_r;
  logic [DIR_W-1:0] dir_nxt;
  logic             advance;
  logic             step_en;

  assign advance = !out_valid_r || out_chan.ready;
  assign step_en = in_valid_r && advance;
  assign in_chan.ready = !in_valid_r || advance;

  qdec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qdec_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .chan_a  (chan_a_r),
    .chan_b  (chan_b_r),
    .cfg     (cfg),
    .dir_nxt (dir_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      chan_a_r <= in_chan.chan_a;
      chan_b_r <= in_chan.chan_b;
    end
    if (step_en) begin
      dir_out_r <= dir_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.speed_direction = dir_out_r;

endmodule

// ----- design/qdec_cfg.sv -----
// Configuration registers of the quadrature decoder.
// Depends on qdec_pkg for register codes, reset values and the cfg_t bundle.
module qdec_cfg import qdec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE_LIMIT:  cfg_nxt.debounce_limit  = cfg_data;
        REG_FAST_LIMIT:      cfg_nxt.fast_limit      = cfg_data;
        REG_SLOW_LIMIT:      cfg_nxt.slow_limit      = cfg_data;
        REG_FAST_MULTIPLIER: cfg_nxt.fast_multiplier = cfg_data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit  <= DEBOUNCE_LIMIT_RST;
      cfg_r.fast_limit      <= FAST_LIMIT_RST;
      cfg_r.slow_limit      <= SLOW_LIMIT_RST;
      cfg_r.fast_multiplier <= FAST_MULTIPLIER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/qdec_core.sv -----
// Decoder state and its per-sample update: phase tracking, tick timer and step classification.
// Depends on qdec_pkg for the configuration bundle and the Gray step table.
module qdec_core import qdec_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             chan_a,
  input  logic             chan_b,
  input  cfg_t             cfg,
  output logic [DIR_W-1:0] dir_nxt
);

  localparam int CMP_W = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;

  logic [1:0]            last_phase_r, last_phase_nxt;
  logic                  known_r, known_nxt;
  logic                  running_r, running_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [DIR_W-1:0]      dir_r;

  logic [1:0]            phase;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic [CMP_W-1:0]      tick_ext;
  logic [CMP_W-1:0]      inc_ext;
  logic [CMP_W-1:0]      deb_ext;
  logic [CMP_W-1:0]      fast_ext;
  logic [CMP_W-1:0]      slow_ext;
  logic [DIR_W-1:0]      mag;
  sense_t                sense;

  assign phase    = {chan_a, chan_b};
  // The counter saturates at its maximum.
  assign tick_inc = (&tick_r) ? tick_r : tick_r + 1'b1;
  assign tick_ext = CMP_W'(tick_r);
  assign inc_ext  = CMP_W'(tick_inc);
  assign deb_ext  = CMP_W'(cfg.debounce_limit);
  assign fast_ext = CMP_W'(cfg.fast_limit);
  assign slow_ext = CMP_W'(cfg.slow_limit);
  assign mag      = DIR_W'(cfg.fast_multiplier);
  assign sense    = step_sense(last_phase_r, phase);

  always_comb begin
    last_phase_nxt = last_phase_r;
    known_nxt      = known_r;
    running_nxt    = running_r;
    tick_nxt       = tick_r;
    dir_nxt        = dir_r;
    if (!known_r) begin
      last_phase_nxt = phase;
      known_nxt      = 1'b1;
    end else if (phase == last_phase_r) begin
      if (running_r) begin
        if (inc_ext > slow_ext) begin
          tick_nxt    = '0;
          running_nxt = 1'b0;
          dir_nxt     = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end else begin
        tick_nxt = '0;
      end
    end else begin
      last_phase_nxt = phase;
      tick_nxt       = '0;
      case (sense)
        SENSE_UP, SENSE_DOWN: begin
          running_nxt = 1'b1;
          if (tick_ext <= deb_ext) begin
            // Bounce: the step is ignored.
          end else if (tick_ext <= fast_ext) begin
            dir_nxt = (sense == SENSE_UP) ? mag : DIR_W'(0) - mag;
          end else if (tick_ext <= slow_ext) begin
            dir_nxt = (sense == SENSE_UP) ? DIR_W'(1) : '1;
          end else begin
            dir_nxt     = '0;
            running_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= '0;
      known_r      <= 1'b0;
      running_r    <= 1'b0;
      tick_r       <= '0;
      dir_r        <= '0;
    end else if (step_en) begin
      last_phase_r <= last_phase_nxt;
      known_r      <= known_nxt;
      running_r    <= running_nxt;
      tick_r       <= tick_nxt;
      dir_r        <= dir_nxt;
    end
  end

endmodule

// ----- bench/qdec_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the quadrature decoder bench: a cycle-free model of the decoder
// that predicts one speed report per accepted sample and checks the reports in order.
// Depends on qdec_pkg for widths, register codes, reset values and the sense codes.
package qdec_tb_pkg;
  import qdec_pkg::*;

  localparam int TICK_W = 16;

  // Position of a phase along the increasing Gray order 00, 10, 11, 01.
  function automatic int gray_pos(input logic [1:0] ph);
    case (ph)
      2'b00: gray_pos = 0;
      2'b10: gray_pos = 1;
      2'b11: gray_pos = 2;
      default: gray_pos = 3;
    endcase
  endfunction

  function automatic logic [1:0] gray_phase(input int pos);
    case (pos & 3)
      0: gray_phase = 2'b00;
      1: gray_phase = 2'b10;
      2: gray_phase = 2'b11;
      default: gray_phase = 2'b01;
    endcase
  endfunction

  class speed_scoreboard;
    logic [LIMIT_W-1:0] debounce_lim;
    logic [LIMIT_W-1:0] fast_lim;
    logic [LIMIT_W-1:0] slow_lim;
    logic [MULT_W-1:0] fast_mult;
    logic [1:0] last_phase;
    bit phase_known;
    bit timer_on;
    logic [TICK_W-1:0] ticks;
    logic signed [DIR_W-1:0] direction;
    logic signed [DIR_W-1:0] expected_dirs[$];
    int errors;

    function new();
      debounce_lim = DEBOUNCE_LIMIT_RST;
      fast_lim = FAST_LIMIT_RST;
      slow_lim = SLOW_LIMIT_RST;
      fast_mult = FAST_MULTIPLIER_RST;
      last_phase = 2'b00;
      phase_known = 1'b0;
      timer_on = 1'b0;
      ticks = '0;
      direction = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [LIMIT_W-1:0] val);
      case (idx)
        REG_DEBOUNCE_LIMIT: debounce_lim = val;
        REG_FAST_LIMIT: fast_lim = val;
        REG_SLOW_LIMIT: slow_lim = val;
        REG_FAST_MULTIPLIER: fast_mult = val[MULT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_dirs.size();
    endfunction

    function void note_sample(logic a, logic b);
      logic [1:0] phase;
      sense_t sense;
      logic signed [DIR_W-1:0] mag;
      phase = {a, b};
      if (!phase_known) begin
        last_phase = phase;
        phase_known = 1'b1;
      end else if (phase == last_phase) begin
        if (timer_on) begin
          if (ticks != '1) ticks++;
          if (ticks > slow_lim) begin
            ticks = '0;
            timer_on = 1'b0;
            direction = '0;
          end
        end else begin
          ticks = '0;
        end
      end else begin
        case ((gray_pos(phase) - gray_pos(last_phase)) & 3)
          1: sense = SENSE_UP;
          3: sense = SENSE_DOWN;
          default: sense = SENSE_NONE;
        endcase
        last_phase = phase;
        if (sense != SENSE_NONE) begin
          timer_on = 1'b1;
          mag = signed'({1'b0, fast_mult});
          if (ticks <= debounce_lim) begin
            // At or below the debounce limit the step leaves the report alone.
          end else if (ticks <= fast_lim) begin
            direction = (sense == SENSE_UP) ? mag : -mag;
          end else if (ticks <= slow_lim) begin
            direction = (sense == SENSE_UP) ? 5'sd1 : -5'sd1;
          end else begin
            direction = '0;
            timer_on = 1'b0;
          end
        end
        ticks = '0;
      end
      expected_dirs.push_back(direction);
    endfunction

    function void check_report(logic signed [DIR_W-1:0] got);
      logic signed [DIR_W-1:0] want;
      if (expected_dirs.size() == 0) begin
        errors++;
        $display("%0t: speed_direction expected none, got %0d", $time, got);
        return;
      end
      want = expected_dirs.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: speed_direction expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the quadrature decoder bench: drives encoder samples and limit writes,
// stalls both channels at random and checks every speed report against qdec_tb_pkg.
// Depends on qdec_pkg, qdec_if, quadrature_decoder_with_speed and qdec_tb_pkg.
module tb_top;
  import qdec_pkg::*;
  import qdec_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [LIMIT_W-1:0] cfg_data;

  qdec_in_if in_chan ();
  qdec_out_if out_chan ();

  speed_scoreboard sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  bit quiet = 1'b0;
  logic [1:0] cur_phase = 2'b00;
  int items_sent = 0;

  quadrature_decoder_with_speed #(.TICK_WIDTH(TICK_W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) sb.note_sample(in_chan.chan_a, in_chan.chan_b);
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_report(out_chan.speed_direction);
  end

  // Receiver back-pressure in random bursts.
  initial begin
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_phase(input logic [1:0] ph);
    int gap;
    if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.chan_a <= ph[1];
    in_chan.chan_b <= ph[0];
    do @(posedge clk); while (!in_chan.ready);
    cur_phase = ph;
    items_sent++;
  endtask

  task automatic hold_phase(input int n);
    repeat (n) send_phase(cur_phase);
  endtask

  task automatic step_phase(input bit up);
    send_phase(gray_phase(gray_pos(cur_phase) + (up ? 1 : 3)));
  endtask

  task automatic skip_phase();
    send_phase(gray_phase(gray_pos(cur_phase) + 2));
  endtask

  // Lowers valid and waits until every report is back and the pipeline is empty.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [LIMIT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input logic [LIMIT_W-1:0] deb, fst, slw,
                              input logic [MULT_W-1:0] mult);
    logic [LIMIT_W-1:0] junk;
    junk = LIMIT_W'($urandom);
    put_reg(REG_DEBOUNCE_LIMIT, deb);
    put_reg(REG_FAST_LIMIT, fst);
    put_reg(REG_SLOW_LIMIT, slw);
    // Upper data bits are don't-care for the multiplier and get random values.
    put_reg(REG_FAST_MULTIPLIER, {junk[LIMIT_W-1:MULT_W], mult});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit(input int base, input int spread);
    int v;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    v = base + $urandom_range(0, spread);
    if (v > 65535) v = 65535;
    return LIMIT_W'(v);
  endfunction

  task automatic random_config();
    logic [LIMIT_W-1:0] deb;
    logic [LIMIT_W-1:0] fst;
    logic [LIMIT_W-1:0] slw;
    deb = pick_limit(0, 6);
    // Now and then the limits come out of order.
    fst = ($urandom_range(0, 5) == 0) ? pick_limit(0, 30) : pick_limit(deb, 20);
    slw = ($urandom_range(0, 5) == 0) ? pick_limit(0, 60) : pick_limit(fst, 40);
    write_config(deb, fst, slw, MULT_W'($urandom_range(0, 15)));
  endtask

  task automatic pick_pressure();
    case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 15;
      default: idle_pct = 40;
    endcase
    case ($urandom_range(0, 2))
      0: stall_pct = 0;
      1: stall_pct = 15;
      default: stall_pct = 40;
    endcase
  endtask

  // Mostly a hold aimed at one speed band followed by a Gray step, plus skips and noise.
  task automatic random_moves(input int n_items, input int cap);
    int first;
    int kind;
    int lo;
    int hi;
    int hold;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        case ($urandom_range(0, 3))
          0: begin lo = 0; hi = int'(sb.debounce_lim); end
          1: begin lo = int'(sb.debounce_lim) + 1; hi = int'(sb.fast_lim); end
          2: begin lo = int'(sb.fast_lim) + 1; hi = int'(sb.slow_lim); end
          default: begin lo = int'(sb.slow_lim) + 1; hi = int'(sb.slow_lim) + 3; end
        endcase
        if (hi > cap) hi = cap;
        if (lo > hi) begin
          hold = $urandom_range(0, 8);
        end else begin
          case ($urandom_range(0, 3))
            0: hold = lo;
            1: hold = hi;
            default: hold = $urandom_range(lo, hi);
          endcase
        end
        hold_phase(hold);
        step_phase($urandom_range(0, 1));
      end else if (kind < 90) begin
        skip_phase();
      end else begin
        send_phase(2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    int start_items;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.chan_a <= 1'b0;
    in_chan.chan_b <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEBOUNCE_LIMIT;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: seed, bounce, fast, skip, both directions.
    idle_pct = 20;
    stall_pct = 20;
    send_phase(2'b00);
    step_phase(1'b1);
    hold_phase(3);
    step_phase(1'b1);
    hold_phase(1);
    step_phase(1'b0);
    skip_phase();
    hold_phase(2);
    step_phase(1'b0);
    hold_phase(4);
    step_phase(1'b0);
    random_moves(300, 1100);

    // Tight limits: fast and slow steps, a hold right at the slow limit, then a step
    // that times out because the slow limit was lowered under the running count.
    drain();
    write_config(16'd0, 16'd2, 16'd4, 4'd15);
    hold_phase(1);
    step_phase(1'b1);
    hold_phase(3);
    step_phase(1'b0);
    hold_phase(4);
    drain();
    write_config(16'd0, 16'd2, 16'd2, 4'd15);
    step_phase(1'b1);
    hold_phase(2);

    start_items = items_sent;
    while (items_sent - start_items < 1000) begin
      drain();
      random_config();
      pick_pressure();
      random_moves(150, 300);
    end

    // With the slow limit at its maximum a held phase does not time out.
    drain();
    idle_pct = 0;
    stall_pct = 0;
    write_config(16'd0, 16'd1, 16'hFFFF, 4'd9);
    step_phase(1'b1);
    hold_phase(1);
    step_phase(1'b1);
    hold_phase(2);
    step_phase(1'b0);
    hold_phase(40);
    drain();
    write_config(16'd0, 16'd1, 16'hFFFE, 4'd0);
    hold_phase(2);

    drain();
    quiet = 1'b1;
    random_config();
    random_moves(200, 300);
    drain();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
